### sv/pfor_bit_width_selector_macros.svh
// assertion helpers shared by the selector rtl
`ifndef PFOR_BIT_WIDTH_SELECTOR_MACROS_SVH
`define PFOR_BIT_WIDTH_SELECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PFOR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfor assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define PFOR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfor assertion failed");

`endif

### sv/pfor_pkg.sv
package pfor_pkg;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int LEN_W      = 8;
  localparam int WID_W      = 6;
  localparam int COST_OUT_W = 10;

  // block size bound
  localparam int BLOCK_MAX_DEFAULT = 128;
  localparam int CNT_W_DEFAULT     = $clog2(BLOCK_MAX_DEFAULT + 1);

  // histogram of widths 0..32
  localparam int HIST_DEPTH = 33;

  localparam logic [LEN_W-1:0] LEN_RESET = 8'd128;

  // strategy codes
  localparam logic [WID_W-1:0] STRAT_PLAIN = 6'd0;
  localparam logic [WID_W-1:0] STRAT_VBYTE = 6'd33;
  localparam logic [WID_W-1:0] STRAT_CONST = 6'd34;

  // vbyte increments exist only below this width
  localparam logic [WID_W-1:0] VBYTE_LIMIT = 6'd26;

  // distances at which a width feeds 1x, 2x, 3x, 4x its count
  localparam int TAP_A = 7;
  localparam int TAP_B = 15;
  localparam int TAP_C = 19;
  localparam int TAP_D = 25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_CHECK,
    ST_MUL,
    ST_PLAIN,
    ST_READ,
    ST_EVAL,
    ST_FIN,
    ST_EMIT
  } pfor_state_t;

  // sequencer to cost unit
  typedef struct packed {
    logic mul_en;
    logic mul_plain;
    logic init_best;
    logic eval_en;
  } pfor_cost_ctl_t;

  // bit width of a value (index of highest set bit plus one)
  function automatic logic [WID_W-1:0] width_of(input logic [VALUE_W-1:0] v);
    logic [WID_W-1:0] w;
    w = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v[i]) begin
        w = WID_W'(i + 1);
      end
    end
    return w;
  endfunction

endpackage

### sv/pfor_ram.sv
module pfor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/pfor_cost_unit.sv
module pfor_cost_unit import pfor_pkg::*; #(
  parameter int CNT_W = CNT_W_DEFAULT,
  localparam int COST_W = CNT_W + WID_W
) (
  input  logic              clk,
  input  pfor_cost_ctl_t    ctl,
  input  logic [CNT_W-1:0]  n,
  input  logic [CNT_W-1:0]  exc,
  input  logic [WID_W-1:0]  maxw,
  input  logic [WID_W-1:0]  w,
  input  logic [COST_W-1:0] nb,
  input  logic [COST_W-1:0] vb,
  output logic [COST_W-1:0] prod,
  output logic [COST_W-1:0] best_cost,
  output logic [WID_W-1:0]  best_width,
  output logic              vbyte_chosen
);

  logic [COST_W-1:0] mul_a;
  logic [COST_W-1:0] mul_b;
  logic [COST_W-1:0] base;
  logic [COST_W-1:0] pad_n;
  logic [COST_W-1:0] pad_p;
  logic [COST_W-1:0] bcost;
  logic [COST_W-1:0] vcost;
  logic              bitmap_ok;
  logic              take_bitmap;
  logic              take_vbyte;

  // shared multiplier: n * maxw for plain cost, exceptions * patch bits per step
  always_comb begin
    mul_a = ctl.mul_plain ? COST_W'(n) : COST_W'(exc);
    mul_b = ctl.mul_plain ? COST_W'(maxw) : COST_W'(maxw - w);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // byte costs at the current base width
  always_comb begin
    base        = ((nb + COST_W'(7)) >> 3) + COST_W'(2);
    pad_n       = (COST_W'(n) + COST_W'(7)) >> 3;
    pad_p       = (prod + COST_W'(7)) >> 3;
    bcost       = base + pad_n + pad_p;
    vcost       = base + COST_W'(exc) + vb;
    bitmap_ok   = (bcost < best_cost) && (bcost <= vcost);
    take_bitmap = ctl.eval_en && bitmap_ok;
    take_vbyte  = ctl.eval_en && !bitmap_ok && (vcost < best_cost);
  end

  // running best choice
  always_ff @(posedge clk) begin
    if (ctl.init_best) begin
      best_cost    <= pad_p + COST_W'(1);
      best_width   <= maxw;
      vbyte_chosen <= 1'b0;
    end else if (take_bitmap) begin
      best_cost    <= bcost;
      best_width   <= w;
      vbyte_chosen <= 1'b0;
    end else if (take_vbyte) begin
      best_cost    <= vcost;
      best_width   <= w;
      vbyte_chosen <= 1'b1;
    end
  end

endmodule

### sv/pfor_bit_width_selector.sv
// a value transaction is an accept in idle, then the histogram write-back
// all-zero or constant block: result goes from check to emit, then into the output register
// other blocks: result follows a sweep of base widths from maxw down to 0 (maxw = width of the block OR)
// input: a new value is taken only in idle, after the previous write-back; the input stalls from the last value
//   of a block until its result loads, longer while the previous result waits in the output register
// reset: synchronous, clears control, block counters and histogram valid bits; length 128
`include "pfor_bit_width_selector_macros.svh"

module pfor_bit_width_selector import pfor_pkg::*; #(
  parameter int BLOCK_MAX = BLOCK_MAX_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_wdata,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [VALUE_W-1:0]    value,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [WID_W-1:0]      base_width,
  output logic [WID_W-1:0]      strategy,
  output logic [COST_OUT_W-1:0] cost_bytes
);

  localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
  localparam int COST_W = CNT_W + WID_W;

  pfor_state_t state;
  pfor_state_t state_next;
  pfor_cost_ctl_t ctl;

  logic [LEN_W-1:0]      len_reg;
  logic [CNT_W-1:0]      n;
  logic [VALUE_W-1:0]    or_acc;
  logic [VALUE_W-1:0]    first_value;
  logic [CNT_W-1:0]      equal_count;
  logic [CNT_W-1:0]      items_seen;
  logic [CNT_W-1:0]      items_seen_next;
  logic                  last_flag;
  logic [HIST_DEPTH-1:0] hist_valid;
  logic                  hist_rvalid;
  logic [WID_W-1:0]      inc_addr;
  logic [WID_W-1:0]      v_w;
  logic [WID_W-1:0]      or_w;
  logic [VALUE_W-1:0]    first_sel;
  logic                  accept;
  logic                  can_load;

  logic                  hist_we;
  logic                  hist_re;
  logic [WID_W-1:0]      hist_raddr;
  logic [CNT_W-1:0]      hist_rdata;
  logic [CNT_W-1:0]      hist_cnt;
  logic [CNT_W-1:0]      hist_wdata;

  logic [WID_W-1:0]      maxw;
  logic [WID_W-1:0]      w;
  logic [CNT_W-1:0]      exc;
  logic [COST_W-1:0]     vb;
  logic [COST_W-1:0]     nb;
  logic [CNT_W-1:0]      taps [TAP_D];
  logic [COST_W-1:0]     inc_sum;

  logic [COST_W-1:0]     prod;
  logic [COST_W-1:0]     best_cost;
  logic [WID_W-1:0]      best_width;
  logic                  vbyte_chosen;

  logic [WID_W-1:0]      res_width;
  logic [WID_W-1:0]      res_strat;
  logic [COST_OUT_W-1:0] res_cost;

  // block length register
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LEN_RESET;
    end else if (cfg_we) begin
      len_reg <= cfg_wdata;
    end
  end

  // effective block length: zero acts as one, saturate at the bound
  always_comb begin
    if (len_reg == '0) begin
      n = CNT_W'(1);
    end else if ({1'b0, len_reg} > (LEN_W + 1)'(BLOCK_MAX)) begin
      n = CNT_W'(BLOCK_MAX);
    end else begin
      n = CNT_W'(len_reg);
    end
  end

  assign accept          = item_valid && (state == ST_IDLE);
  assign item_stall      = (state != ST_IDLE);
  assign can_load        = !result_valid || !result_stall;
  assign v_w             = width_of(value);
  assign or_w            = width_of(or_acc);
  assign first_sel       = (items_seen == '0) ? value : first_value;
  assign items_seen_next = items_seen + CNT_W'(1);
  assign hist_cnt        = hist_rvalid ? hist_rdata : '0;
  assign hist_wdata      = hist_cnt + CNT_W'(1);
  assign hist_raddr      = (state == ST_READ) ? w : v_w;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    ctl           = '0;
    hist_we       = 1'b0;
    hist_re       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          hist_re    = 1'b1;
          state_next = ST_INC;
        end
      end
      ST_INC: begin
        hist_we    = 1'b1;
        state_next = last_flag ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (or_acc == '0 || equal_count >= n) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul_en    = 1'b1;
        ctl.mul_plain = 1'b1;
        state_next    = ST_PLAIN;
      end
      ST_PLAIN: begin
        ctl.init_best = 1'b1;
        state_next    = ST_READ;
      end
      ST_READ: begin
        hist_re    = 1'b1;
        ctl.mul_en = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        ctl.eval_en = (w != maxw);
        state_next  = (w == '0) ? ST_FIN : ST_READ;
      end
      ST_FIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // per-value accumulation and block clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      or_acc      <= '0;
      equal_count <= '0;
      items_seen  <= '0;
      hist_valid  <= '0;
      last_flag   <= 1'b0;
    end else if (accept) begin
      or_acc      <= or_acc | value;
      if (value == first_sel) begin
        equal_count <= equal_count + CNT_W'(1);
      end
      last_flag   <= (items_seen_next >= n);
      items_seen  <= (items_seen_next >= n) ? '0 : items_seen_next;
    end else if (state == ST_INC) begin
      hist_valid[inc_addr] <= 1'b1;
    end else if (state == ST_EMIT && can_load) begin
      or_acc      <= '0;
      equal_count <= '0;
      hist_valid  <= '0;
    end
  end

  // payload side of accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      if (items_seen == '0) begin
        first_value <= value;
      end
      inc_addr    <= v_w;
      hist_rvalid <= hist_valid[v_w];
    end else if (state == ST_READ) begin
      hist_rvalid <= hist_valid[w];
    end
  end

  // width histogram
  pfor_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (inc_addr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // vbyte increment for the width joining now
  always_comb begin
    if (w < VBYTE_LIMIT) begin
      inc_sum = COST_W'(taps[TAP_A-1])
              + COST_W'(2) * COST_W'(taps[TAP_B-1])
              + COST_W'(3) * COST_W'(taps[TAP_C-1])
              + COST_W'(4) * COST_W'(taps[TAP_D-1]);
    end else begin
      inc_sum = '0;
    end
  end

  // sweep datapath: base width index, exceptions, vbyte bytes, n*b
  always_ff @(posedge clk) begin
    unique case (state)
      ST_CHECK: begin
        maxw <= or_w;
      end
      ST_MUL: begin
        w   <= maxw;
        exc <= '0;
        vb  <= '0;
        for (int i = 0; i < TAP_D; i++) begin
          taps[i] <= '0;
        end
      end
      ST_PLAIN: begin
        nb <= prod;
      end
      ST_EVAL: begin
        exc     <= exc + hist_cnt;
        vb      <= vb + COST_W'(hist_cnt) + inc_sum;
        nb      <= nb - COST_W'(n);
        taps[0] <= hist_cnt;
        for (int i = 1; i < TAP_D; i++) begin
          taps[i] <= taps[i-1];
        end
        if (w != '0) begin
          w <= w - WID_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  pfor_cost_unit #(
    .CNT_W (CNT_W)
  ) u_cost (
    .clk          (clk),
    .ctl          (ctl),
    .n            (n),
    .exc          (exc),
    .maxw         (maxw),
    .w            (w),
    .nb           (nb),
    .vb           (vb),
    .prod         (prod),
    .best_cost    (best_cost),
    .best_width   (best_width),
    .vbyte_chosen (vbyte_chosen)
  );

  // result fields: special blocks in check, sweep outcome in fin
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      if (or_acc == '0) begin
        res_width <= '0;
        res_strat <= STRAT_PLAIN;
        res_cost  <= COST_OUT_W'(1);
      end else begin
        res_width <= or_w;
        res_strat <= STRAT_CONST;
        res_cost  <= ((COST_OUT_W'(or_w) + COST_OUT_W'(7)) >> 3) + COST_OUT_W'(1);
      end
    end else if (state == ST_FIN) begin
      res_width <= best_width;
      res_cost  <= best_cost[COST_OUT_W-1:0];
      if (vbyte_chosen) begin
        res_strat <= STRAT_VBYTE;
      end else if (best_width == maxw) begin
        res_strat <= STRAT_PLAIN;
      end else begin
        res_strat <= maxw - best_width;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT && can_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && can_load) begin
      base_width <= res_width;
      strategy   <= res_strat;
      cost_bytes <= res_cost;
    end
  end

  `PFOR_ASSERT_NXT(a_accept_blocks_next, item_valid && !item_stall, item_stall)
  `PFOR_ASSERT_IMP(a_sweep_in_range, state == ST_READ || state == ST_EVAL, w <= maxw)
  `PFOR_ASSERT_NXT(a_emit_clears_hist, state == ST_EMIT && can_load, hist_valid == '0 && result_valid)
  `PFOR_ASSERT_IMP(a_const_cost, result_valid && strategy == STRAT_CONST, cost_bytes != '0 && cost_bytes <= COST_OUT_W'(5))

endmodule

### tb/sv/pfor_bit_width_selector_checker.sv
`timescale 1ns / 1ps

module pfor_bit_width_selector_checker import pfor_pkg::*; #(
  parameter int BLOCK_MAX = BLOCK_MAX_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_wdata,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  logic [VALUE_W-1:0]    value,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [WID_W-1:0]      base_width,
  input  logic [WID_W-1:0]      strategy,
  input  logic [COST_OUT_W-1:0] cost_bytes,
  output int                    pending,
  output int                    fail_count
);

  localparam int VB_N         = VBYTE_LIMIT;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [WID_W-1:0]      base;
    logic [WID_W-1:0]      strat;
    logic [COST_OUT_W-1:0] cost;
  } packing_t;

  // running statistics of the block being collected
  int                 width_count [HIST_DEPTH];
  int                 vbyte_extra [VB_N];
  logic [VALUE_W-1:0] or_all;
  logic [VALUE_W-1:0] lead_value;
  int                 same_count;
  int                 seen;
  logic [LEN_W-1:0]   len_reg;
  packing_t           pending_choices [$];
  int                 errors = 0;

  assign fail_count = errors;

  // position of the highest set bit plus one
  function automatic int bit_width(input logic [VALUE_W-1:0] v);
    int w;
    w = 0;
    for (int i = VALUE_W - 1; i >= 0; i--) begin
      if (v[i] && w == 0) begin
        w = i + 1;
      end
    end
    return w;
  endfunction

  function automatic int bytes_for(input int bits);
    return (bits + 7) / 8;
  endfunction

  // a width feeds 1x..4x its count into the vbyte increments below it
  function automatic void spread_count(input int cnt, input int w);
    int taps [4];
    taps = '{TAP_A, TAP_B, TAP_C, TAP_D};
    for (int k = 0; k < 4; k++) begin
      if (w >= taps[k] && w - taps[k] < VB_N) begin
        vbyte_extra[w - taps[k]] += cnt * (k + 1);
      end
    end
  endfunction

  function automatic void clear_block_state();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      width_count[i] = 0;
    end
    for (int i = 0; i < VB_N; i++) begin
      vbyte_extra[i] = 0;
    end
    or_all     = '0;
    lead_value = '0;
    same_count = 0;
    seen       = 0;
  endfunction

  // sweep base widths and pick the cheapest packing of the finished block
  function automatic packing_t choose_packing(input int n);
    packing_t r;
    int       maxw, best, bw, exc, vb, base_b, vcost, bcost;
    bit       via_vbyte;
    r = '0;
    if (or_all == '0) begin
      r.cost = COST_OUT_W'(1);
      return r;
    end
    maxw = bit_width(or_all);
    if (same_count == n) begin
      r.base  = WID_W'(maxw);
      r.strat = STRAT_CONST;
      r.cost  = COST_OUT_W'(bytes_for(maxw) + 1);
      return r;
    end
    for (int i = 0; i < VB_N; i++) begin
      vbyte_extra[i] = 0;
    end
    bw        = maxw;
    best      = bytes_for(n * maxw) + 1;
    via_vbyte = 1'b0;
    exc       = width_count[maxw];
    vb        = exc;
    spread_count(exc, maxw);
    for (int b = maxw - 1; b >= 0; b--) begin
      base_b = bytes_for(n * b) + 2;
      vcost  = base_b + exc + vb;
      bcost  = base_b + bytes_for(n) + bytes_for(exc * (maxw - b));
      if (bcost < best && bcost <= vcost) begin
        best      = bcost;
        bw        = b;
        via_vbyte = 1'b0;
      end else if (vcost < best) begin
        best      = vcost;
        bw        = b;
        via_vbyte = 1'b1;
      end
      exc += width_count[b];
      vb  += width_count[b] + ((b < VB_N) ? vbyte_extra[b] : 0);
      spread_count(width_count[b], b);
    end
    r.base = WID_W'(bw);
    if (via_vbyte) begin
      r.strat = STRAT_VBYTE;
    end else if (bw == maxw) begin
      r.strat = STRAT_PLAIN;
    end else begin
      r.strat = WID_W'(maxw - bw);
    end
    r.cost = COST_OUT_W'(best);
    return r;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin : watch
    packing_t want;
    int       n;
    if (rst) begin
      clear_block_state();
      len_reg = LEN_RESET;
      pending_choices.delete();
    end else begin
      // input transaction: update statistics, predict at block end
      if (item_valid && !item_stall) begin
        n = (len_reg == 0) ? 1 : ((len_reg > BLOCK_MAX) ? BLOCK_MAX : int'(len_reg));
        if (seen == 0) begin
          lead_value = value;
        end
        or_all |= value;
        if (value == lead_value) begin
          same_count++;
        end
        width_count[bit_width(value)]++;
        seen++;
        if (seen >= n) begin
          if (same_count > n) begin
            same_count = n;
          end
          pending_choices.insert(pending_choices.size(), choose_packing(n));
          clear_block_state();
        end
      end
      // result transaction: compare with the oldest prediction
      if (result_valid && !result_stall) begin
        if (pending_choices.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected result transaction: base %0d strategy %0d cost %0d",
                     base_width, strategy, cost_bytes);
          end
        end else begin
          want = pending_choices.pop_front();
          if (want.base !== base_width || want.strat !== strategy ||
              want.cost !== cost_bytes) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display({"mismatch: expected base %0d strategy %0d cost %0d, ",
                        "got base %0d strategy %0d cost %0d"},
                       want.base, want.strat, want.cost, base_width, strategy, cost_bytes);
            end
          end
        end
      end
      if (cfg_we) begin
        len_reg = cfg_wdata;
      end
    end
    pending <= pending_choices.size();
  end

endmodule

### tb/sv/pfor_bit_width_selector_tb.sv
`timescale 1ns / 1ps

module pfor_bit_width_selector_tb import pfor_pkg::*; ();

  localparam int BLOCK_MAX     = BLOCK_MAX_DEFAULT;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int IDLE_PCT      = 24;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [LEN_W-1:0]      cfg_wdata;
  logic                  item_valid;
  logic                  item_stall;
  logic [VALUE_W-1:0]    value;
  logic                  result_valid;
  logic                  result_stall;
  logic [WID_W-1:0]      base_width;
  logic [WID_W-1:0]      strategy;
  logic [COST_OUT_W-1:0] cost_bytes;
  int                    pending;
  int                    fail_count;
  logic                  quiet;
  logic                  hold_req;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pfor_bit_width_selector #(
    .BLOCK_MAX(BLOCK_MAX)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .base_width  (base_width),
    .strategy    (strategy),
    .cost_bytes  (cost_bytes)
  );

  pfor_bit_width_selector_checker #(
    .BLOCK_MAX(BLOCK_MAX)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .base_width  (base_width),
    .strategy    (strategy),
    .cost_bytes  (cost_bytes),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  // watchdog
  initial begin
    #4_000_000;
    $display("pfor_bit_width_selector_tb NOT OK");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int  left;
    bit  held;
    left = 0;
    held = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        result_stall <= 1'b1;
      end else if (quiet) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // offer one value, with random gaps before it, and wait for the transaction
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    value      <= v;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
  endtask

  // stop offering and let every predicted result come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(19))
      0:       return '0;
      1:       return LEN_W'(1);
      2:       return LEN_W'(BLOCK_MAX);
      3:       return '1;
      4:       return LEN_W'($urandom_range(255, BLOCK_MAX + 1));
      5, 6:    return LEN_W'($urandom_range(BLOCK_MAX, 17));
      default: return LEN_W'($urandom_range(16, 2));
    endcase
  endfunction

  // one block of values, shaped to hit every cost strategy
  task automatic send_block(input int n);
    int                 kind;
    int                 b;
    logic [VALUE_W-1:0] lead;
    logic [VALUE_W-1:0] low_mask;
    logic [VALUE_W-1:0] v;
    kind     = $urandom_range(7);
    b        = $urandom_range(12);
    lead     = $urandom;
    low_mask = (32'd1 << b) - 32'd1;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = '0;
        1: v = lead;
        2: v = ($urandom_range(9) == 0) ? lead ^ (32'd1 << $urandom_range(31)) : lead;
        3, 4: begin
          v = $urandom & low_mask;
          if ($urandom_range(7) == 0) begin
            v = $urandom >> $urandom_range(31);
          end
        end
        5: v = $urandom >> $urandom_range(32);
        default: v = $urandom;
      endcase
      send_value(v);
    end
  endtask

  initial begin : stimulus
    int               n;
    int               blocks;
    int               sent;
    logic [LEN_W-1:0] len;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    item_valid <= 1'b0;
    value      <= '0;
    quiet      <= 1'b0;
    hold_req   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero length acts as one: zero, all-ones and one-bit values
    write_length('0);
    send_value('0);
    send_value('1);
    send_value(32'd1);

    // all-zero, constant and one wide exception
    write_length(LEN_W'(4));
    repeat (4) send_value('0);
    repeat (4) send_value(32'd5);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value('1);

    // length shrinks mid-block below the items already seen
    write_length(LEN_W'(8));
    repeat (3) send_value(32'd6);
    write_length(LEN_W'(2));
    send_value(32'd6);

    // mixed narrow values with a top-bit exception
    write_length(LEN_W'(6));
    send_value(32'd1);
    send_value('0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'h8000_0000);

    // long receiver hold-off with one-value blocks so the block backs up
    write_length(LEN_W'(1));
    hold_req <= 1'b1;
    repeat (40) send_value($urandom);

    // stretch with no idling on either side
    write_length(LEN_W'(3));
    quiet <= 1'b1;
    repeat (100) send_block(3);
    quiet <= 1'b0;
    sent = 365;

    // random phases over block lengths
    while (sent < RANDOM_ITEMS) begin
      len = pick_length();
      write_length(len);
      n = (len == 0) ? 1 : ((len > BLOCK_MAX) ? BLOCK_MAX : int'(len));
      blocks = (n >= 64) ? 1 : 1 + $urandom_range(120 / n);
      repeat (blocks) send_block(n);
      sent += n * blocks;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("pfor_bit_width_selector_tb OK");
    end else begin
      $display("pfor_bit_width_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/pfor_pkg.sv
sv/pfor_ram.sv
sv/pfor_cost_unit.sv
sv/pfor_bit_width_selector.sv
tb/sv/pfor_bit_width_selector_checker.sv
tb/sv/pfor_bit_width_selector_tb.sv
